// ----- hdl/csd_pkg.sv -----
// Shared types, codes and constants for the container section deframer.
package csd_pkg;

   // Field counter width; covers field lengths up to 63 bytes
   localparam int CNT_W = 6;

   localparam logic [CNT_W-1:0] MAGIC_LEN  = CNT_W'(12);
   localparam logic [CNT_W-1:0] HEADER_LEN = CNT_W'(16);
   localparam logic [CNT_W-1:0] LENGTH_LEN = CNT_W'(4);
   localparam logic [CNT_W-1:0] TYPE_KEEP  = CNT_W'(4);
   localparam logic [31:0]      TOC_CODE   = 32'h894C_464D;
   localparam logic [15:0]      SEC_MAX    = 16'hFFFF;

   // Parser phase; each value equals the code of the byte class of the same name
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_GAP     = 3'd1,
      PH_TYPE    = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_HASH    = 3'd4,
      PH_PAD     = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_ERROR   = 3'd7
   } phase_type;

   // Byte class codes on the result channel
   localparam logic [2:0] CLS_HEADER  = 3'd0;
   localparam logic [2:0] CLS_GAP     = 3'd1;
   localparam logic [2:0] CLS_TYPE    = 3'd2;
   localparam logic [2:0] CLS_LENGTH  = 3'd3;
   localparam logic [2:0] CLS_HASH    = 3'd4;
   localparam logic [2:0] CLS_PAD     = 3'd5;
   localparam logic [2:0] CLS_PAYLOAD = 3'd6;
   localparam logic [2:0] CLS_ERROR   = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  byte_value;
      logic [15:0] section_number;
      logic [31:0] payload_length;
      logic        is_toc_section;
      logic        payload_end;
      logic        magic_error;
   } rsp_type;

   // Expected file magic, one byte per header position
   function automatic logic [7:0] magic_byte(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = 8'h89;
         4'd1:    val = 8'h4C;
         4'd2:    val = 8'h46;
         4'd3:    val = 8'h50;
         4'd4:    val = 8'h0D;
         4'd5:    val = 8'h0A;
         4'd6:    val = 8'h1A;
         4'd7:    val = 8'h0A;
         4'd8:    val = 8'h00;
         4'd9:    val = 8'h00;
         4'd10:   val = 8'h00;
         4'd11:   val = 8'h01;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ----- hdl/csd_if.sv -----
// Valid/ready channel interfaces for the request and response streams.
interface csd_req_if;
   import csd_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface csd_rsp_if;
   import csd_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/csd_in_reg.sv -----
// Input register stage: captures one request transaction per cycle while req_chan.ready is high.
module csd_in_reg (
   input  logic            clock,
   input  logic            reset,
   csd_req_if.sink         req_chan,
   input  logic            take,
   output logic            in_valid,
   output csd_pkg::req_type in_data
);
   import csd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // Accept when empty or when the held transaction moves on this cycle
   assign req_chan.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_chan.ready) begin
         valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on every accepted transaction
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         data_ff <= req_chan.data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;
endmodule

// ----- hdl/csd_parser.sv -----
// Section parser: phase state machine, field counters and result forming.
module csd_parser #(
   parameter int HASH_LEN       = 45,
   parameter int PAD_LEN        = 35,
   parameter int TYPE_FIELD_LEN = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  csd_pkg::req_type in_data,
   input  logic             out_free,
   output logic             take,
   output csd_pkg::rsp_type result
);
   import csd_pkg::*;

   localparam logic [CNT_W-1:0] HASH_END = CNT_W'(HASH_LEN);
   localparam logic [CNT_W-1:0] PAD_END  = CNT_W'(PAD_LEN);
   localparam logic [CNT_W-1:0] TYPE_END = CNT_W'(TYPE_FIELD_LEN);

   phase_type        phase_ff, phase_in, phase_st;
   logic [CNT_W-1:0] fc_ff, fc_in, fc_st, fc_inc;
   logic [31:0]      len_ff, len_in, len_st;
   logic [31:0]      rem_ff, rem_in, rem_st, rem_dec;
   logic [31:0]      type_ff, type_in, type_st;
   logic [15:0]      sec_ff, sec_in;
   logic             mbad_ff, mbad_in, mbad_st;
   logic [2:0]       cls;
   logic             len_valid;
   logic             pend;
   logic             finish;
   logic [7:0]       b;

   assign take    = in_valid && out_free;
   assign b       = in_data.data_byte;
   assign fc_inc  = fc_ff + CNT_W'(1);
   assign rem_dec = rem_ff - 32'd1;

   // Advance the parse by one byte (before section end and end-of-file clears)
   always_comb begin
      phase_st  = phase_ff;
      fc_st     = fc_ff;
      len_st    = len_ff;
      rem_st    = rem_ff;
      type_st   = type_ff;
      mbad_st   = mbad_ff;
      cls       = CLS_ERROR;
      len_valid = 1'b0;
      pend      = 1'b0;
      finish    = 1'b0;
      unique case (phase_ff)
         PH_HEADER: begin
            cls = CLS_HEADER;
            if (fc_ff < MAGIC_LEN && b != magic_byte(fc_ff[3:0])) begin
               mbad_st = 1'b1;
            end
            fc_st = fc_inc;
            if (fc_inc >= HEADER_LEN) begin
               fc_st    = '0;
               phase_st = mbad_st ? PH_ERROR : PH_GAP;
            end
         end
         PH_GAP: begin
            if (b == 8'h00) begin
               cls = CLS_GAP;
            end else begin
               cls      = CLS_TYPE;
               type_st  = {24'h0, b};
               len_st   = '0;
               fc_st    = CNT_W'(1);
               phase_st = PH_TYPE;
               if (CNT_W'(1) >= TYPE_END) begin
                  fc_st    = '0;
                  phase_st = PH_LENGTH;
               end
            end
         end
         PH_TYPE: begin
            cls = CLS_TYPE;
            if (fc_ff < TYPE_KEEP) begin
               type_st = {type_ff[23:0], b};
            end
            fc_st = fc_inc;
            if (fc_inc >= TYPE_END) begin
               fc_st    = '0;
               phase_st = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            cls    = CLS_LENGTH;
            len_st = {len_ff[23:0], b};
            fc_st  = fc_inc;
            if (fc_inc >= LENGTH_LEN) begin
               fc_st     = '0;
               len_valid = 1'b1;
               phase_st  = PH_HASH;
            end
         end
         PH_HASH: begin
            cls       = CLS_HASH;
            len_valid = 1'b1;
            fc_st     = fc_inc;
            if (fc_inc >= HASH_END) begin
               fc_st = '0;
               if (PAD_END != '0) begin
                  phase_st = PH_PAD;
               end else if (len_ff == '0) begin
                  finish = 1'b1;
               end else begin
                  rem_st   = len_ff;
                  phase_st = PH_PAYLOAD;
               end
            end
         end
         PH_PAD: begin
            cls       = CLS_PAD;
            len_valid = 1'b1;
            fc_st     = fc_inc;
            if (fc_inc >= PAD_END) begin
               fc_st = '0;
               if (len_ff == '0) begin
                  finish = 1'b1;
               end else begin
                  rem_st   = len_ff;
                  phase_st = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            cls       = CLS_PAYLOAD;
            len_valid = 1'b1;
            rem_st    = rem_dec;
            if (rem_dec == '0) begin
               pend   = 1'b1;
               finish = 1'b1;
            end
         end
         PH_ERROR: begin
            cls = CLS_ERROR;
         end
         default: begin
            cls = CLS_ERROR;
         end
      endcase
   end

   // Next state: apply section end, then end-of-file restart
   always_comb begin
      phase_in = phase_ff;
      fc_in    = fc_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      type_in  = type_ff;
      sec_in   = sec_ff;
      mbad_in  = mbad_ff;
      if (take) begin
         phase_in = phase_st;
         fc_in    = fc_st;
         len_in   = len_st;
         rem_in   = rem_st;
         type_in  = type_st;
         mbad_in  = mbad_st;
         if (finish) begin
            phase_in = PH_GAP;
            fc_in    = '0;
            type_in  = '0;
            len_in   = '0;
            rem_in   = '0;
            if (sec_ff != SEC_MAX) begin
               sec_in = sec_ff + 16'd1;
            end
         end
         if (in_data.end_of_file) begin
            phase_in = PH_HEADER;
            fc_in    = '0;
            len_in   = '0;
            rem_in   = '0;
            type_in  = '0;
            sec_in   = '0;
            mbad_in  = 1'b0;
         end
      end
   end

   // Form the result for the byte taken this cycle
   always_comb begin
      result.byte_class     = cls;
      result.byte_value     = b;
      result.section_number = sec_ff;
      result.payload_length = len_valid ? len_st : 32'd0;
      result.is_toc_section = (type_st == TOC_CODE);
      result.payload_end    = pend;
      result.magic_error    = mbad_st;
      if (cls == CLS_HEADER || cls == CLS_ERROR) begin
         result.is_toc_section = 1'b0;
      end
      if (cls == CLS_ERROR) begin
         result.section_number = '0;
         result.payload_length = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         fc_ff    <= '0;
         len_ff   <= '0;
         rem_ff   <= '0;
         type_ff  <= '0;
         sec_ff   <= '0;
         mbad_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         fc_ff    <= fc_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         type_ff  <= type_in;
         sec_ff   <= sec_in;
         mbad_ff  <= mbad_in;
      end
   end

   // End of file always restarts at a clean header
   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      take && in_data.end_of_file |=> phase_ff == PH_HEADER && fc_ff == '0 && !mbad_ff)
      else $error("parser did not restart after end of file");

   // Error phase is only reachable through a bad magic
   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |-> mbad_ff)
      else $error("error phase without magic mismatch");

   // Payload phase always has bytes left to deliver
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> rem_ff != '0)
      else $error("payload phase with nothing remaining");

   // Header counter stays within the header
   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> fc_ff < HEADER_LEN)
      else $error("header counter out of range");
endmodule

// ----- hdl/csd_out_reg.sv -----
// Result register: holds one response transaction until the sink takes it.
module csd_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  csd_pkg::rsp_type result,
   output logic             out_free,
   csd_rsp_if.source        rsp_chan
);
   import csd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Room when empty or when the held result leaves this cycle
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new result whenever the parser takes a byte
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.data  = data_ff;
endmodule

// ----- hdl/container_section_deframer_core.sv -----
// Top level of the byte-serial container section deframer.
//
//  channel   dir  payload                                       handshake
//  req_chan  in   data_byte, end_of_file                         valid/ready
//  rsp_chan  out  byte_class, byte_value, section_number,        valid/ready
//                 payload_length, is_toc_section, payload_end,
//                 magic_error
//
// One byte per cycle sustained while rsp_chan is ready; one response per request byte.
// A response is offered on rsp_chan from the result register after its request
// passes through the input register, then the parse logic.
// Synchronous active-high reset returns the parser to the header phase.
// A stall on rsp_chan holds the result register, then the input register,
// then drops req_chan.ready; no transaction is lost.
module container_section_deframer_core #(
   parameter int HASH_LEN       = 45,
   parameter int PAD_LEN        = 35,
   parameter int TYPE_FIELD_LEN = 12
) (
   input logic       clock,
   input logic       reset,
   csd_req_if.sink   req_chan,
   csd_rsp_if.source rsp_chan
);
   import csd_pkg::*;

   logic    in_valid;
   req_type in_data;
   logic    take;
   logic    out_free;
   rsp_type result;

   csd_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .in_valid (in_valid),
      .in_data  (in_data)
   );

   csd_parser #(
      .HASH_LEN       (HASH_LEN),
      .PAD_LEN        (PAD_LEN),
      .TYPE_FIELD_LEN (TYPE_FIELD_LEN)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_data  (in_data),
      .out_free (out_free),
      .take     (take),
      .result   (result)
   );

   csd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );
endmodule
